/* sv/btr_pkg.sv */
// shared constants, command and status types of the triangle rasterizer
`default_nettype none

package btr_pkg;

  // default geometry
  localparam int unsigned SCREEN_SIZE_DEF = 768;
  localparam int unsigned COORD_FRAC_DEF  = 4;

  // fixed field and datapath widths
  localparam int POS_W      = 16;
  localparam int TEX_W      = 17;
  localparam int DIFF_W     = 17;
  localparam int DIV_W      = 34;
  localparam int RECIP_BITS = 40;
  localparam int HALF_BITS  = 20;
  localparam int MAC_W      = 58;
  localparam int SAMPLE_W   = 16;
  localparam int PIX_W      = 10;
  localparam int COLOR_W    = 8;
  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 2;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // vertex slots
  localparam logic [SLOT_W-1:0] SLOT_A = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_B = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_C = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_MISS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAG = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK = 2'd2;

  // signed edge multiplier operand pairs
  typedef enum logic [2:0] {
    E_D_A, E_D_B, E_NU_A, E_NU_B, E_NV_A, E_NV_B
  } esel_e;

  // edge accumulator destinations
  typedef enum logic [1:0] {
    ED_NONE, ED_D, ED_NU, ED_NV
  } edst_e;

  // unsigned multiplier wide operand
  typedef enum logic [2:0] {
    UA_NU, UA_NV, UA_W, UA_TA, UA_TB, UA_TC
  } ua_e;

  // unsigned multiplier narrow operand source
  typedef enum logic [1:0] {
    UB_INV, UB_UQ, UB_VQ, UB_WQ
  } ub_e;

  // mac destinations
  typedef enum logic [2:0] {
    UD_NONE, UD_UQ, UD_VQ, UD_WQ, UD_SU, UD_SV
  } udst_e;

  typedef struct packed {
    logic              load;
    logic              setup;
    esel_e             esel;
    logic              efirst;
    edst_e             edst;
    logic              div_init;
    logic              div_step;
    ua_e               ua;
    logic              ucomp;
    ub_e               ub;
    logic              uhi;
    logic              ufirst;
    udst_e             udst;
    logic              scan_start;
    logic              scan_adv;
    logic              capture;
    logic              mark;
    logic [SLOT_W-1:0] mark_idx;
  } btr_cmd_t;

  typedef struct packed {
    logic covered;
    logic empty;
    logic scan_last;
    logic tex_mode;
  } btr_stat_t;

endpackage

`default_nettype wire

/* sv/btr_ctrl.sv */
// sequencer of setup, reciprocal, per-pixel multiplies and result beats
`default_nettype none

module btr_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        opcode_i,
  input  wire logic [btr_pkg::SLOT_W-1:0]  vertex_slot_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  input  wire btr_pkg::btr_stat_t          stat_i,
  output btr_pkg::btr_cmd_t                cmd_o
);
  import btr_pkg::*;

  localparam int CNT_W = $clog2(RECIP_BITS + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SETUP  = 7'b0000010,
    ST_DIV    = 7'b0000100,
    ST_EDGE   = 7'b0001000,
    ST_WEIGHT = 7'b0010000,
    ST_TEX    = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SCAN   = 5'b00010,
    PH_MARK_A = 5'b00100,
    PH_MARK_B = 5'b01000,
    PH_MARK_C = 5'b10000
  } phase_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic [CNT_W-1:0]  tk;
  logic [1:0]        tj;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // texture product index within one component
  always_comb begin
    tk = (cnt_q >= CNT_W'(6)) ? cnt_q - CNT_W'(6) : cnt_q;
    tj = tk[2:1];
  end

  // next state and command
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q + CNT_W'(1);
    out_valid_d = out_valid_q && out_stall_i;

    cmd_o            = '0;
    cmd_o.esel       = E_D_A;
    cmd_o.efirst     = 1'b1;
    cmd_o.edst       = ED_NONE;
    cmd_o.ua         = UA_NU;
    cmd_o.ub         = UB_INV;
    cmd_o.ufirst     = 1'b1;
    cmd_o.udst       = UD_NONE;
    cmd_o.mark_idx   = SLOT_A;

    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          if (opcode_i == OP_LOAD) begin
            if (vertex_slot_i inside {SLOT_A, SLOT_B, SLOT_C}) begin
              cmd_o.load = 1'b1;
              phase_d    = PH_IDLE;
              if (vertex_slot_i == SLOT_C) state_d = ST_SETUP;
            end
          end else begin
            case (phase_q)
              PH_SCAN:                          state_d = ST_EDGE;
              PH_MARK_A, PH_MARK_B, PH_MARK_C:  state_d = ST_EMIT;
              default:                          phase_d = PH_IDLE;
            endcase
          end
        end
      end

      // box, texture mode and the two products of the denominator
      ST_SETUP: begin
        if (cnt_q == '0) begin
          cmd_o.setup = 1'b1;
          cmd_o.esel  = E_D_A;
        end else begin
          cmd_o.esel   = E_D_B;
          cmd_o.efirst = 1'b0;
          cmd_o.edst   = ED_D;
          state_d      = ST_DIV;
          cnt_d        = '0;
        end
      end

      // one quotient bit per cycle
      ST_DIV: begin
        if (cnt_q == '0) cmd_o.div_init = 1'b1;
        else             cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(RECIP_BITS)) begin
          state_d = ST_IDLE;
          if (stat_i.empty) begin
            phase_d = PH_MARK_A;
          end else begin
            phase_d          = PH_SCAN;
            cmd_o.scan_start = 1'b1;
          end
        end
      end

      // nu and nv of the current pixel
      ST_EDGE: begin
        case (cnt_q)
          CNT_W'(0): cmd_o.esel = E_NU_A;
          CNT_W'(1): begin
            cmd_o.esel   = E_NU_B;
            cmd_o.efirst = 1'b0;
            cmd_o.edst   = ED_NU;
          end
          CNT_W'(2): cmd_o.esel = E_NV_A;
          CNT_W'(3): begin
            cmd_o.esel   = E_NV_B;
            cmd_o.efirst = 1'b0;
            cmd_o.edst   = ED_NV;
          end
          CNT_W'(4): ;
          default: begin
            state_d = stat_i.covered ? ST_WEIGHT : ST_EMIT;
            cnt_d   = '0;
          end
        endcase
      end

      // uq, vq, wq as two half products each
      ST_WEIGHT: begin
        if (cnt_q < CNT_W'(6)) begin
          case (cnt_q[2:1])
            2'd0:    cmd_o.ua = UA_NU;
            2'd1:    cmd_o.ua = UA_NV;
            default: cmd_o.ua = UA_W;
          endcase
          cmd_o.ub     = UB_INV;
          cmd_o.uhi    = cnt_q[0];
          cmd_o.ufirst = !cnt_q[0];
          if (cnt_q[0]) begin
            case (cnt_q[2:1])
              2'd0:    cmd_o.udst = UD_UQ;
              2'd1:    cmd_o.udst = UD_VQ;
              default: cmd_o.udst = UD_WQ;
            endcase
          end
        end else begin
          state_d = stat_i.tex_mode ? ST_TEX : ST_EMIT;
          cnt_d   = '0;
        end
      end

      // texture sums, u component then v component
      ST_TEX: begin
        if (cnt_q < CNT_W'(12)) begin
          case (tj)
            2'd0: begin
              cmd_o.ua = UA_TC;
              cmd_o.ub = UB_UQ;
            end
            2'd1: begin
              cmd_o.ua = UA_TB;
              cmd_o.ub = UB_VQ;
            end
            default: begin
              cmd_o.ua = UA_TA;
              cmd_o.ub = UB_WQ;
            end
          endcase
          cmd_o.ucomp  = (cnt_q >= CNT_W'(6));
          cmd_o.uhi    = tk[0];
          cmd_o.ufirst = (tk == '0);
          if (tk == CNT_W'(5)) cmd_o.udst = cmd_o.ucomp ? UD_SV : UD_SU;
        end else begin
          state_d = ST_EMIT;
        end
      end

      // load the output register once it is free
      ST_EMIT: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
          case (phase_q)
            PH_SCAN: begin
              cmd_o.scan_adv = 1'b1;
              if (stat_i.scan_last) phase_d = PH_MARK_A;
            end
            PH_MARK_A: begin
              cmd_o.mark     = 1'b1;
              cmd_o.mark_idx = SLOT_A;
              phase_d        = PH_MARK_B;
            end
            PH_MARK_B: begin
              cmd_o.mark     = 1'b1;
              cmd_o.mark_idx = SLOT_B;
              phase_d        = PH_MARK_C;
            end
            default: begin
              cmd_o.mark     = 1'b1;
              cmd_o.mark_idx = SLOT_C;
              phase_d        = PH_IDLE;
            end
          endcase
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* sv/btr_dpath.sv */
// vertex store, setup, edge and weight multipliers, divider and output register
`default_nettype none

module btr_dpath #(
  parameter int unsigned SCREEN_SIZE     = btr_pkg::SCREEN_SIZE_DEF,
  parameter int unsigned COORD_FRAC_BITS = btr_pkg::COORD_FRAC_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire btr_pkg::btr_cmd_t                  cmd_i,
  output btr_pkg::btr_stat_t                      stat_o,
  input  wire logic [btr_pkg::SLOT_W-1:0]         vertex_slot_i,
  input  wire logic signed [btr_pkg::POS_W-1:0]   vertex_x_i,
  input  wire logic signed [btr_pkg::POS_W-1:0]   vertex_y_i,
  input  wire logic [btr_pkg::TEX_W-1:0]          tex_coord_u_i,
  input  wire logic [btr_pkg::TEX_W-1:0]          tex_coord_v_i,
  output logic [btr_pkg::PIX_W-1:0]               pixel_x_o,
  output logic [btr_pkg::PIX_W-1:0]               pixel_y_o,
  output logic [btr_pkg::KIND_W-1:0]              kind_o,
  output logic [btr_pkg::COLOR_W-1:0]             red_o,
  output logic [btr_pkg::COLOR_W-1:0]             green_o,
  output logic [btr_pkg::COLOR_W-1:0]             blue_o,
  output logic                                    textured_o,
  output logic [btr_pkg::SAMPLE_W-1:0]            sample_u_o,
  output logic [btr_pkg::SAMPLE_W-1:0]            sample_v_o,
  output logic                                    last_o
);
  import btr_pkg::*;

  localparam int CW  = $clog2(SCREEN_SIZE);
  localparam int SW  = (CW + COORD_FRAC_BITS > POS_W) ? CW + COORD_FRAC_BITS : POS_W;
  localparam int V2W = SW + 2;
  localparam int EW  = V2W + DIFF_W;
  localparam int AW  = EW + 1;
  localparam int PW  = DIV_W + HALF_BITS;
  localparam logic signed [POS_W:0] SMAX = (POS_W+1)'(SCREEN_SIZE - 1);

  // truncate a position toward zero to whole pixels
  function automatic logic signed [POS_W:0] to_pix(input logic signed [POS_W-1:0] q);
    logic signed [POS_W:0] e;
    logic [POS_W:0]        m;
    e = (POS_W+1)'(q);
    m = e[POS_W] ? -e : e;
    m = m >> COORD_FRAC_BITS;
    return e[POS_W] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [POS_W:0] clamp_scr(input logic signed [POS_W:0] p);
    logic signed [POS_W:0] r;
    r = p;
    if (p < 0)    r = '0;
    if (p > SMAX) r = SMAX;
    return r;
  endfunction

  // vertex store
  logic signed [POS_W-1:0] px_q [3];
  logic signed [POS_W-1:0] py_q [3];
  logic [TEX_W-1:0]        tu_q [3];
  logic [TEX_W-1:0]        tv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        px_q[i] <= '0;
        py_q[i] <= '0;
        tu_q[i] <= '0;
        tv_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        if (vertex_slot_i == SLOT_W'(i)) begin
          px_q[i] <= vertex_x_i;
          py_q[i] <= vertex_y_i;
          tu_q[i] <= tex_coord_u_i;
          tv_q[i] <= tex_coord_v_i;
        end
      end
    end
  end

  // bounding box and texture mode
  logic signed [POS_W-1:0] mnx, mxx, mny, mxy;
  logic signed [POS_W:0]   blo_x, bhi_x, blo_y, bhi_y;
  logic [CW-1:0]           lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic                    empty_q, tex_mode_q, tex_ok;

  always_comb begin
    mnx = px_q[0];
    mxx = px_q[0];
    mny = py_q[0];
    mxy = py_q[0];
    for (int i = 1; i < 3; i++) begin
      if (px_q[i] < mnx) mnx = px_q[i];
      if (px_q[i] > mxx) mxx = px_q[i];
      if (py_q[i] < mny) mny = py_q[i];
      if (py_q[i] > mxy) mxy = py_q[i];
    end
    blo_x = to_pix(mnx);
    bhi_x = to_pix(mxx);
    blo_y = to_pix(mny);
    bhi_y = to_pix(mxy);
    if (blo_x < 0)    blo_x = '0;
    if (blo_y < 0)    blo_y = '0;
    if (bhi_x > SMAX) bhi_x = SMAX;
    if (bhi_y > SMAX) bhi_y = SMAX;
    tex_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (tu_q[i][TEX_W-1] || tv_q[i][TEX_W-1]) tex_ok = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_x_q     <= '0;
      hi_x_q     <= '0;
      lo_y_q     <= '0;
      hi_y_q     <= '0;
      empty_q    <= 1'b0;
      tex_mode_q <= 1'b0;
    end else if (cmd_i.setup) begin
      lo_x_q     <= CW'(blo_x);
      hi_x_q     <= CW'(bhi_x);
      lo_y_q     <= CW'(blo_y);
      hi_y_q     <= CW'(bhi_y);
      empty_q    <= (blo_x > bhi_x) || (blo_y > bhi_y);
      tex_mode_q <= tex_ok;
    end
  end

  // scan position
  logic [CW-1:0] scan_x_q, scan_y_q;
  logic          scan_last;

  assign scan_last = (scan_x_q == hi_x_q) && (scan_y_q == hi_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_x_q <= '0;
      scan_y_q <= '0;
    end else if (cmd_i.scan_start) begin
      scan_x_q <= lo_x_q;
      scan_y_q <= lo_y_q;
    end else if (cmd_i.scan_adv) begin
      if (scan_x_q < hi_x_q) begin
        scan_x_q <= scan_x_q + CW'(1);
      end else begin
        scan_x_q <= lo_x_q;
        if (scan_y_q < hi_y_q) scan_y_q <= scan_y_q + CW'(1);
      end
    end
  end

  // edge vectors
  logic signed [DIFF_W-1:0] v0x, v0y, v1x, v1y;
  logic signed [V2W-1:0]    v2x, v2y;

  always_comb begin
    v0x = DIFF_W'(px_q[2]) - DIFF_W'(px_q[0]);
    v0y = DIFF_W'(py_q[2]) - DIFF_W'(py_q[0]);
    v1x = DIFF_W'(px_q[1]) - DIFF_W'(px_q[0]);
    v1y = DIFF_W'(py_q[1]) - DIFF_W'(py_q[0]);
    v2x = $signed(V2W'(scan_x_q) << COORD_FRAC_BITS) - V2W'(px_q[0]);
    v2y = $signed(V2W'(scan_y_q) << COORD_FRAC_BITS) - V2W'(py_q[0]);
  end

  // signed edge multiplier
  logic signed [V2W-1:0]    ea;
  logic signed [DIFF_W-1:0] eb;
  logic signed [EW-1:0]     e_prod_q;
  logic                     efirst_q;
  edst_e                    edst_q;
  logic signed [AW-1:0]     e_acc_q, e_acc_d, e_fix;
  logic signed [AW-1:0]     nu_q, nv_q;
  logic [DIV_W-1:0]         d_abs_q;
  logic                     d_neg_q;

  always_comb begin
    case (cmd_i.esel)
      E_D_A: begin
        ea = V2W'(v0x);
        eb = v1y;
      end
      E_D_B: begin
        ea = V2W'(v0y);
        eb = v1x;
      end
      E_NU_A: begin
        ea = v2x;
        eb = v1y;
      end
      E_NU_B: begin
        ea = v2y;
        eb = v1x;
      end
      E_NV_A: begin
        ea = v2y;
        eb = v0x;
      end
      E_NV_B: begin
        ea = v2x;
        eb = v0y;
      end
      default: begin
        ea = '0;
        eb = '0;
      end
    endcase
  end

  assign e_acc_d = efirst_q ? AW'(e_prod_q) : e_acc_q - AW'(e_prod_q);
  assign e_fix   = d_neg_q ? -e_acc_d : e_acc_d;

  always_ff @(posedge clk_i) begin
    e_prod_q <= EW'(ea * eb);
    e_acc_q  <= e_acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      efirst_q <= 1'b1;
      edst_q   <= ED_NONE;
      nu_q     <= '0;
      nv_q     <= '0;
      d_abs_q  <= '0;
      d_neg_q  <= 1'b0;
    end else begin
      efirst_q <= cmd_i.efirst;
      edst_q   <= cmd_i.edst;
      case (edst_q)
        ED_D: begin
          d_neg_q <= e_acc_d[AW-1];
          d_abs_q <= DIV_W'(e_acc_d[AW-1] ? -e_acc_d : e_acc_d);
        end
        ED_NU:   nu_q <= e_fix;
        ED_NV:   nv_q <= e_fix;
        default: ;
      endcase
    end
  end

  // coverage test
  logic signed [AW:0] uv_sum, d_ext;
  logic               covered;
  logic [DIV_W-1:0]   w_val;

  always_comb begin
    uv_sum  = (AW+1)'(nu_q) + (AW+1)'(nv_q);
    d_ext   = $signed((AW+1)'(d_abs_q));
    covered = (d_abs_q != '0) && !nu_q[AW-1] && !nv_q[AW-1] && (uv_sum < d_ext);
    w_val   = DIV_W'(d_ext - uv_sum);
  end

  // reciprocal, restoring division of all ones by d
  logic [DIV_W:0]        rem_q;
  logic [DIV_W+1:0]      r2;
  logic                  qbit;
  logic [RECIP_BITS-1:0] inv_q;

  always_comb begin
    r2   = {rem_q, 1'b1};
    qbit = (d_abs_q != '0) && (r2 >= (DIV_W+2)'(d_abs_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      inv_q <= '0;
    end else if (cmd_i.div_init) begin
      rem_q <= '0;
      inv_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? (DIV_W+1)'(r2 - (DIV_W+2)'(d_abs_q)) : (DIV_W+1)'(r2);
      inv_q <= {inv_q[RECIP_BITS-2:0], qbit};
    end
  end

  // unsigned weight multiplier and accumulator
  logic [DIV_W-1:0]      ua_val;
  logic [RECIP_BITS-1:0] ub_src;
  logic [HALF_BITS-1:0]  ub_val;
  logic [PW-1:0]         u_prod_q;
  logic                  uhi_q, ufirst_q;
  udst_e                 udst_q;
  logic [MAC_W-1:0]      mac_q, mac_d, mac_add;
  logic [RECIP_BITS-1:0] uq_q, vq_q, wq_q;
  logic [SAMPLE_W-1:0]   su_q, sv_q;

  always_comb begin
    case (cmd_i.ua)
      UA_NU:   ua_val = DIV_W'(nu_q);
      UA_NV:   ua_val = DIV_W'(nv_q);
      UA_W:    ua_val = w_val;
      UA_TA:   ua_val = DIV_W'(cmd_i.ucomp ? tv_q[0] : tu_q[0]);
      UA_TB:   ua_val = DIV_W'(cmd_i.ucomp ? tv_q[1] : tu_q[1]);
      UA_TC:   ua_val = DIV_W'(cmd_i.ucomp ? tv_q[2] : tu_q[2]);
      default: ua_val = '0;
    endcase
    case (cmd_i.ub)
      UB_INV:  ub_src = inv_q;
      UB_UQ:   ub_src = uq_q;
      UB_VQ:   ub_src = vq_q;
      UB_WQ:   ub_src = wq_q;
      default: ub_src = '0;
    endcase
    ub_val  = cmd_i.uhi ? ub_src[RECIP_BITS-1:HALF_BITS] : ub_src[HALF_BITS-1:0];
    mac_add = uhi_q ? MAC_W'({u_prod_q, {HALF_BITS{1'b0}}}) : MAC_W'(u_prod_q);
    mac_d   = (ufirst_q ? '0 : mac_q) + mac_add;
  end

  always_ff @(posedge clk_i) begin
    u_prod_q <= PW'(ua_val * ub_val);
    mac_q    <= mac_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uhi_q    <= 1'b0;
      ufirst_q <= 1'b1;
      udst_q   <= UD_NONE;
      uq_q     <= '0;
      vq_q     <= '0;
      wq_q     <= '0;
      su_q     <= '0;
      sv_q     <= '0;
    end else begin
      uhi_q    <= cmd_i.uhi;
      ufirst_q <= cmd_i.ufirst;
      udst_q   <= cmd_i.udst;
      case (udst_q)
        UD_UQ:   uq_q <= mac_d[RECIP_BITS-1:0];
        UD_VQ:   vq_q <= mac_d[RECIP_BITS-1:0];
        UD_WQ:   wq_q <= mac_d[RECIP_BITS-1:0];
        UD_SU:   su_q <= mac_d[RECIP_BITS+SAMPLE_W-1:RECIP_BITS];
        UD_SV:   sv_q <= mac_d[RECIP_BITS+SAMPLE_W-1:RECIP_BITS];
        default: ;
      endcase
    end
  end

  // colors as weight times 255
  logic [RECIP_BITS+COLOR_W-1:0] r255, g255, b255;

  always_comb begin
    r255 = {uq_q, {COLOR_W{1'b0}}} - (RECIP_BITS+COLOR_W)'(uq_q);
    g255 = {wq_q, {COLOR_W{1'b0}}} - (RECIP_BITS+COLOR_W)'(wq_q);
    b255 = {vq_q, {COLOR_W{1'b0}}} - (RECIP_BITS+COLOR_W)'(vq_q);
  end

  // marker position
  logic signed [POS_W-1:0] mk_x, mk_y;

  always_comb begin
    case (cmd_i.mark_idx)
      SLOT_A: begin
        mk_x = px_q[0];
        mk_y = py_q[0];
      end
      SLOT_B: begin
        mk_x = px_q[1];
        mk_y = py_q[1];
      end
      default: begin
        mk_x = px_q[2];
        mk_y = py_q[2];
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      textured_o <= tex_mode_q;
      if (cmd_i.mark) begin
        pixel_x_o  <= PIX_W'(clamp_scr(to_pix(mk_x)));
        pixel_y_o  <= PIX_W'(clamp_scr(to_pix(mk_y)));
        kind_o     <= KIND_MARK;
        red_o      <= '0;
        green_o    <= '1;
        blue_o     <= '1;
        sample_u_o <= '0;
        sample_v_o <= '0;
        last_o     <= (cmd_i.mark_idx == SLOT_C);
      end else begin
        pixel_x_o  <= PIX_W'(scan_x_q);
        pixel_y_o  <= PIX_W'(scan_y_q);
        kind_o     <= covered ? KIND_FRAG : KIND_MISS;
        red_o      <= covered ? r255[RECIP_BITS+COLOR_W-1:RECIP_BITS] : '0;
        green_o    <= covered ? g255[RECIP_BITS+COLOR_W-1:RECIP_BITS] : '0;
        blue_o     <= covered ? b255[RECIP_BITS+COLOR_W-1:RECIP_BITS] : '0;
        sample_u_o <= (covered && tex_mode_q) ? su_q : '0;
        sample_v_o <= (covered && tex_mode_q) ? sv_q : '0;
        last_o     <= 1'b0;
      end
    end
  end

  assign stat_o.covered   = covered;
  assign stat_o.empty     = empty_q;
  assign stat_o.scan_last = scan_last;
  assign stat_o.tex_mode  = tex_mode_q;

endmodule

`default_nettype wire

/* sv/barycentric_triangle_rasterizer.sv */
// top level of the barycentric triangle rasterizer
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o   | opcode, vertex_slot, vertex_x/y, tex_coord_u/v
//   out     | output    | out_valid_o/out_stall_i | pixel_x/y, kind, rgb, textured, sample_u/v, last
//
// loading C runs setup and the bit-serial reciprocal divider, during which
// in_stall_o is high. a step tick over a pixel runs the edge products, then
// the weight products when covered and the texture sums when also textured;
// the shared edge multiplier and the single 34x20 weight multiplier compute
// these products. reset clears all control and vertex state.
// a stalled output beat holds; the next tick waits in its emit cycle.
`default_nettype none

module barycentric_triangle_rasterizer #(
  parameter int unsigned SCREEN_SIZE     = btr_pkg::SCREEN_SIZE_DEF,
  parameter int unsigned COORD_FRAC_BITS = btr_pkg::COORD_FRAC_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               opcode_i,
  input  wire logic [btr_pkg::SLOT_W-1:0]         vertex_slot_i,
  input  wire logic signed [btr_pkg::POS_W-1:0]   vertex_x_i,
  input  wire logic signed [btr_pkg::POS_W-1:0]   vertex_y_i,
  input  wire logic [btr_pkg::TEX_W-1:0]          tex_coord_u_i,
  input  wire logic [btr_pkg::TEX_W-1:0]          tex_coord_v_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [btr_pkg::PIX_W-1:0]               pixel_x_o,
  output logic [btr_pkg::PIX_W-1:0]               pixel_y_o,
  output logic [btr_pkg::KIND_W-1:0]              kind_o,
  output logic [btr_pkg::COLOR_W-1:0]             red_o,
  output logic [btr_pkg::COLOR_W-1:0]             green_o,
  output logic [btr_pkg::COLOR_W-1:0]             blue_o,
  output logic                                    textured_o,
  output logic [btr_pkg::SAMPLE_W-1:0]            sample_u_o,
  output logic [btr_pkg::SAMPLE_W-1:0]            sample_v_o,
  output logic                                    last_o
);
  import btr_pkg::*;

  btr_cmd_t  cmd;
  btr_stat_t stat;

  // sequencer
  btr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .vertex_slot_i (vertex_slot_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // arithmetic and storage
  btr_dpath #(
    .SCREEN_SIZE     (SCREEN_SIZE),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .vertex_slot_i (vertex_slot_i),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .tex_coord_u_i (tex_coord_u_i),
    .tex_coord_v_i (tex_coord_v_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .kind_o        (kind_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .textured_o    (textured_o),
    .sample_u_o    (sample_u_o),
    .sample_v_o    (sample_v_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  // a held output beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> !(out_valid_o && out_stall_i))
    else $error("output register loaded while a beat is held");

  // last flag only on a marker beat
  a_last_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> kind_o == KIND_MARK)
    else $error("last flag on a pixel beat");

  // vertex store is written only while the input side is open
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> in_valid_i && !in_stall_o && opcode_i == OP_LOAD)
    else $error("vertex written without an accepted load beat");
`endif

endmodule

`default_nettype wire

/* dv/barycentric_triangle_rasterizer_test.sv */
// self-checking testbench of the barycentric triangle rasterizer
`default_nettype none

module barycentric_triangle_rasterizer_test;
  import btr_pkg::*;

  // one result beat
  typedef struct packed {
    logic [PIX_W-1:0]    px;
    logic [PIX_W-1:0]    py;
    logic [KIND_W-1:0]   kind;
    logic [COLOR_W-1:0]  r;
    logic [COLOR_W-1:0]  g;
    logic [COLOR_W-1:0]  b;
    logic                textured;
    logic [SAMPLE_W-1:0] su;
    logic [SAMPLE_W-1:0] sv;
    logic                last;
  } pixel_beat_t;

  typedef enum int {ST_IDLE, ST_SCAN, ST_MARK_A, ST_MARK_B, ST_MARK_C} raster_state_e;

  localparam int SCREEN = 768;
  localparam int FRAC   = 4;

  // scoreboard: shadow rasterizer plus queue of expected beats
  class raster_scoreboard;
    longint        pos_x[3], pos_y[3];
    longint        tex[3][2];
    longint        lo_x, hi_x, lo_y, hi_y, sx, sy, denom;
    longint unsigned recip;
    bit            tex_on;
    raster_state_e st;
    pixel_beat_t   pending[$];
    int            mismatches;

    function new();
      for (int i = 0; i < 3; i++) begin
        pos_x[i] = 0; pos_y[i] = 0; tex[i][0] = 0; tex[i][1] = 0;
      end
      lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; sx = 0; sy = 0; denom = 0;
      recip = 0; tex_on = 0; st = ST_IDLE; mismatches = 0;
    endfunction

    function longint whole_px(longint q);
      if (q < 0) return -((-q) >>> FRAC);
      return q >>> FRAC;
    endfunction

    function longint clamp_px(longint p);
      if (p < 0) return 0;
      if (p > SCREEN - 1) return SCREEN - 1;
      return p;
    endfunction

    function void triangle_setup();
      longint mnx, mxx, mny, mxy, ad;
      mnx = pos_x[0]; mxx = pos_x[0]; mny = pos_y[0]; mxy = pos_y[0];
      for (int i = 1; i < 3; i++) begin
        if (pos_x[i] < mnx) mnx = pos_x[i];
        if (pos_x[i] > mxx) mxx = pos_x[i];
        if (pos_y[i] < mny) mny = pos_y[i];
        if (pos_y[i] > mxy) mxy = pos_y[i];
      end
      lo_x = whole_px(mnx); hi_x = whole_px(mxx);
      lo_y = whole_px(mny); hi_y = whole_px(mxy);
      if (lo_x < 0) lo_x = 0;
      if (lo_y < 0) lo_y = 0;
      if (hi_x > SCREEN - 1) hi_x = SCREEN - 1;
      if (hi_y > SCREEN - 1) hi_y = SCREEN - 1;
      denom = (pos_x[2] - pos_x[0]) * (pos_y[1] - pos_y[0])
            - (pos_y[2] - pos_y[0]) * (pos_x[1] - pos_x[0]);
      ad = denom < 0 ? -denom : denom;
      recip = ad != 0 ? ((64'd1 << RECIP_BITS) - 1) / longint'(ad) : 0;
      tex_on = 1;
      for (int i = 0; i < 3; i++)
        if (tex[i][0] >= 65536 || tex[i][1] >= 65536) tex_on = 0;
      if (lo_x > hi_x || lo_y > hi_y) st = ST_MARK_A;
      else begin
        st = ST_SCAN; sx = lo_x; sy = lo_y;
      end
    endfunction

    function void scan_one(ref pixel_beat_t e);
      longint v0x, v0y, v1x, v1y, v2x, v2y, d, nu, nv;
      longint unsigned uq, vq, wq, s;
      v0x = pos_x[2] - pos_x[0]; v0y = pos_y[2] - pos_y[0];
      v1x = pos_x[1] - pos_x[0]; v1y = pos_y[1] - pos_y[0];
      v2x = sx * (1 << FRAC) - pos_x[0]; v2y = sy * (1 << FRAC) - pos_y[0];
      d = denom;
      nu = v2x * v1y - v2y * v1x;
      nv = v0x * v2y - v0y * v2x;
      if (d < 0) begin
        d = -d; nu = -nu; nv = -nv;
      end
      if (d != 0 && nu >= 0 && nv >= 0 && nu + nv < d) begin
        uq = nu * recip; vq = nv * recip; wq = (d - nu - nv) * recip;
        e.kind = KIND_FRAG;
        e.r = COLOR_W'((uq * 255) >> RECIP_BITS);
        e.g = COLOR_W'((wq * 255) >> RECIP_BITS);
        e.b = COLOR_W'((vq * 255) >> RECIP_BITS);
        if (tex_on) begin
          s = tex[0][0] * wq + tex[2][0] * uq + tex[1][0] * vq;
          e.su = SAMPLE_W'(s >> RECIP_BITS);
          s = tex[0][1] * wq + tex[2][1] * uq + tex[1][1] * vq;
          e.sv = SAMPLE_W'(s >> RECIP_BITS);
        end
      end
      if (sx < hi_x) sx++;
      else begin
        sx = lo_x;
        if (sy < hi_y) sy++;
        else st = ST_MARK_A;
      end
    endfunction

    // note an accepted input beat
    function void note_input(bit op, logic [1:0] slot, logic signed [15:0] x,
                             logic signed [15:0] y, logic [16:0] tu, logic [16:0] tv);
      pixel_beat_t e;
      int k;
      if (op == OP_LOAD) begin
        if (slot > SLOT_C) return;
        st = ST_IDLE;
        pos_x[slot] = longint'(x); pos_y[slot] = longint'(y);
        tex[slot][0] = longint'(tu); tex[slot][1] = longint'(tv);
        if (slot == SLOT_C) triangle_setup();
        return;
      end
      if (st == ST_IDLE) return;
      e = '{default: 0};
      e.textured = tex_on;
      if (st == ST_SCAN) begin
        e.px = PIX_W'(sx); e.py = PIX_W'(sy);
        scan_one(e);
      end else begin
        k = int'(st) - int'(ST_MARK_A);
        e.px = PIX_W'(clamp_px(whole_px(pos_x[k])));
        e.py = PIX_W'(clamp_px(whole_px(pos_y[k])));
        e.kind = KIND_MARK; e.g = 8'd255; e.b = 8'd255;
        if (k == 2) begin
          e.last = 1; st = ST_IDLE;
        end else st = raster_state_e'(int'(st) + 1);
      end
      pending.push_back(e);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(pixel_beat_t got);
      pixel_beat_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat at (%0d,%0d)", got.px, got.py);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp xy=%0d,%0d k=%0d rgb=%0d,%0d,%0d t=%0d s=%0d,%0d l=%0d",
                    " got xy=%0d,%0d k=%0d rgb=%0d,%0d,%0d t=%0d s=%0d,%0d l=%0d"},
                   e.px, e.py, e.kind, e.r, e.g, e.b, e.textured, e.su, e.sv, e.last,
                   got.px, got.py, got.kind, got.r, got.g, got.b, got.textured,
                   got.su, got.sv, got.last);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic opcode_i = 0;
  logic [SLOT_W-1:0] vertex_slot_i = 0;
  logic signed [POS_W-1:0] vertex_x_i = 0, vertex_y_i = 0;
  logic [TEX_W-1:0] tex_coord_u_i = 0, tex_coord_v_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [PIX_W-1:0] pixel_x_o, pixel_y_o;
  logic [KIND_W-1:0] kind_o;
  logic [COLOR_W-1:0] red_o, green_o, blue_o;
  logic textured_o, last_o;
  logic [SAMPLE_W-1:0] sample_u_o, sample_v_o;

  raster_scoreboard raster_sb = new();
  longint cycles = 0;
  bit     hold_long = 0;
  bit     hold_done = 0;

  always #4 clk_i = ~clk_i;

  barycentric_triangle_rasterizer u_dut (.*);

  // input beats accepted by the block
  always @(posedge clk_i)
    if (rst_ni && in_valid_i && !in_stall_o)
      raster_sb.note_input(opcode_i, vertex_slot_i, vertex_x_i, vertex_y_i,
                           tex_coord_u_i, tex_coord_v_i);

  // result beats accepted from the block
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      raster_sb.check_result('{pixel_x_o, pixel_y_o, kind_o, red_o, green_o, blue_o,
                               textured_o, sample_u_o, sample_v_o, last_o});

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[barycentric_triangle_rasterizer] ERROR");
      $finish;
    end
  end

  // receiver stalls, with one long hold-off and some calm stretches
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1;
        repeat (400) @(posedge clk_i);
        hold_long = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      out_stall_i <= gap != 0;
      repeat (gap) @(posedge clk_i);
      out_stall_i <= 0;
      @(posedge clk_i);
    end
  end

  // drive one input beat with a random lead gap
  task automatic send_beat(bit op, logic [1:0] slot, logic signed [15:0] x,
                           logic signed [15:0] y, logic [16:0] tu, logic [16:0] tv,
                           bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1; opcode_i <= op; vertex_slot_i <= slot;
    vertex_x_i <= x; vertex_y_i <= y; tex_coord_u_i <= tu; tex_coord_v_i <= tv;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_vertex(logic [1:0] slot, int x, int y, int tu, int tv);
    send_beat(OP_LOAD, slot, 16'(x), 16'(y), 17'(tu), 17'(tv));
  endtask

  task automatic send_ticks(int n, bit no_gap = 0);
    for (int i = 0; i < n; i++)
      send_beat(OP_STEP, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                17'($urandom), 17'($urandom), no_gap);
  endtask

  // small random triangle near a random spot, with occasional edge values
  task automatic random_triangle();
    int cx, cy, sz, tu, tv;
    bit wild;
    wild = $urandom_range(0, 9) == 0;
    sz = $urandom_range(8, 90);
    cx = $urandom_range(0, 16'hffff) - 32768;
    cy = $urandom_range(0, 16'hffff) - 32768;
    if ($urandom_range(0, 2) != 0) begin
      cx = $urandom_range(0, 767 * 16);
      cy = $urandom_range(0, 767 * 16);
    end
    for (int s = 0; s < 3; s++) begin
      tu = $urandom_range(0, 65535);
      tv = $urandom_range(0, 65535);
      if ($urandom_range(0, 7) == 0) tu = $urandom_range(0, 131071);
      if (wild) send_vertex(2'(s), $urandom, $urandom, $urandom, $urandom);
      else send_vertex(2'(s), cx + $urandom_range(0, sz) - sz / 2,
                       cy + $urandom_range(0, sz) - sz / 2, tu, tv);
    end
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: tick while idle, bad slot, small textured triangle
    send_ticks(1);
    send_vertex(2'd3, 16, 16, 0, 0);
    send_vertex(SLOT_A, 0, 0, 0, 0);
    send_vertex(SLOT_B, 64, 0, 65535, 0);
    send_vertex(SLOT_C, 0, 48, 0, 65535);
    send_ticks(24);
    // clockwise, off screen corners, untextured, extreme fields
    send_vertex(SLOT_A, -32768, 32767, 131071, 131071);
    send_vertex(SLOT_B, 12280, 12280, 0, 0);
    send_vertex(SLOT_C, 12250, 12300, 65536, 0);
    send_ticks(8);
    // degenerate line, abandoned mid scan by a new load
    send_vertex(SLOT_A, 0, 0, 0, 0);
    send_vertex(SLOT_B, 32, 32, 0, 0);
    send_vertex(SLOT_C, 16, 16, 0, 0);
    send_ticks(3);
    // box entirely off screen
    send_vertex(SLOT_A, -32768, -32768, 0, 0);
    send_vertex(SLOT_B, -32000, -32768, 0, 0);
    send_vertex(SLOT_C, -32768, -32000, 0, 0);
    send_ticks(4);

    // random part; a long receiver hold-off early on
    sent = 0;
    while (sent < 490) begin
      if (sent > 60 && !hold_done) begin
        hold_long = 1;
        hold_done = 1;
      end
      if ($urandom_range(0, 19) == 0) begin
        send_ticks(1);
        sent++;
      end else begin
        random_triangle();
        sent += 3;
        begin
          int n;
          n = $urandom_range(1, 30);
          send_ticks(n, hold_long);
          sent += n;
        end
      end
    end
    in_valid_i <= 0;

    while (raster_sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (raster_sb.mismatches == 0 && raster_sb.pending.size() == 0)
      $display("[barycentric_triangle_rasterizer] OK");
    else
      $display("[barycentric_triangle_rasterizer] ERROR");
    $finish;
  end
endmodule

`default_nettype wire
